@@ src/rk4_planar_ode_stepper_macros.svh @@
// Assertion macros for the planar ODE stepper.
`ifndef RK4_PLANAR_ODE_STEPPER_MACROS_SVH
`define RK4_PLANAR_ODE_STEPPER_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLY(lbl, clk, rstn, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) else $error("lbl");
`define ASSERT_NEXT(lbl, clk, rstn, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) else $error("lbl");
`else
`define ASSERT_IMPLY(lbl, clk, rstn, a, c)
`define ASSERT_NEXT(lbl, clk, rstn, a, c)
`endif
`endif

@@ src/rk4_pkg.sv @@
// Shared types and constants for the planar ODE stepper.
package rk4_pkg;
    localparam logic signed [31:0] I32_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] I32_MIN = 32'sh8000_0000;
    localparam logic [1:0] REG_STEP = 2'd0;
    localparam logic [1:0] REG_GAIN = 2'd1;
    localparam logic [1:0] REG_OFFS = 2'd2;

    typedef struct packed {
        logic start;
        logic signed [31:0] num;
        logic signed [31:0] den;
    } div_req_t;

    typedef struct packed {
        logic done;
        logic sat;
        logic signed [31:0] quo;
    } div_rsp_t;

    function automatic logic signed [31:0] sat64(input logic signed [63:0] v,
                                                  output logic fl);
        begin
            fl = 1'b0;
            if (v > 64'sd2147483647) begin
                fl = 1'b1;
                sat64 = I32_MAX;
            end
            else if (v < -64'sd2147483648) begin
                fl = 1'b1;
                sat64 = I32_MIN;
            end
            else begin
                sat64 = v[31:0];
            end
        end
    endfunction
endpackage

@@ src/rk4_planar_ode_stepper.sv @@
// Top level of the planar ODE stepper: sequencer and shared multiply-add unit.
//
//  channel  direction  handshake          payload
//  in       input      in_valid/in_stall  restart, start_x, start_y
//  out      output     out_valid/out_stall point_x_out, point_y_out, saturated
//  cfg      input      cfg_we             cfg_index, cfg_data
//
// Each of the four stages runs ten microsteps through the single multiplier/adder
// plus a wait in S_DIV on the bit-serial divider, which skips its bit loop when
// Q+y is zero. S_FIN then divides the weighted sum by six and S_UPD updates the
// point, after which out_valid rises and the stepper is back in S_IDLE, ready for
// the next input transfer.
// Reset clears the point to zero and loads default registers.
// A result waits in the output register; the next item is taken once it is
// transferred or while it is being transferred.
module rk4_planar_ode_stepper #(
    parameter int FRACTION_BITS = 24
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               restart,
    input  logic signed [31:0] start_x,
    input  logic signed [31:0] start_y,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] point_x_out,
    output logic signed [31:0] point_y_out,
    output logic               saturated,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data
);
`include "rk4_planar_ode_stepper_macros.svh"

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_RUN  = 5'b00010,
        S_DIV  = 5'b00100,
        S_FIN  = 5'b01000,
        S_UPD  = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic [3:0] op_reg, op_next;
    logic [1:0] stg_reg, stg_next;
    logic [24:0] h_reg;
    logic signed [31:0] p_reg, q_reg;
    logic signed [31:0] x_reg, y_reg;
    logic signed [31:0] sx_reg, sy_reg;
    logic signed [31:0] t0_reg, t1_reg, t2_reg, qt_reg;
    logic signed [31:0] kx_reg, ky_reg;
    logic signed [34:0] accx_reg, accy_reg;
    logic signed [31:0] dvx_reg, dvy_reg;
    logic fl_reg;
    logic signed [31:0] ox_reg, oy_reg;
    logic osat_reg, ovalid_reg;
    logic div_pend_reg;

    rk4_pkg::div_req_t dreq;
    rk4_pkg::div_rsp_t drsp;

    rk4_div #(.FRACTION_BITS(FRACTION_BITS)) u_div (
        .clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    // shared unit: one product or one saturating add/subtract per cycle
    logic signed [31:0] ma, mb;
    logic signed [63:0] prod;
    logic signed [63:0] pshift;
    logic signed [31:0] mres;
    logic mfl;
    logic signed [31:0] aa, ab;
    logic asub;
    logic signed [31:0] ares;
    logic afl;
    logic signed [63:0] one64;
    logic signed [31:0] one_s;
    logic one_fl;
    logic signed [31:0] h_s;

    logic take_in;
    logic signed [31:0] sx_next, sy_next, t0_next, t1_next, t2_next, qt_next;
    logic signed [31:0] kx_next, ky_next, x_next, y_next;
    logic signed [34:0] accx_next, accy_next;
    logic signed [31:0] dvx_next, dvy_next;
    logic fl_next;
    logic dstart;
    logic fx, fy;
    logic signed [31:0] nx, ny;

    assign one64 = 64'sd1 <<< FRACTION_BITS;
    assign h_s = {7'd0, h_reg};

    always_comb
    begin
        one_s = rk4_pkg::sat64(one64, one_fl);
        prod = 64'(ma) * 64'(mb);
        // truncate toward zero
        pshift = (prod < 0) ? -((-prod) >>> FRACTION_BITS) : (prod >>> FRACTION_BITS);
        mres = rk4_pkg::sat64(pshift, mfl);
        ares = rk4_pkg::sat64(asub ? 64'(aa) - 64'(ab) : 64'(aa) + 64'(ab), afl);
    end

    // k/2 truncates toward zero
    function automatic logic signed [31:0] half(input logic signed [31:0] v);
        half = (v < 0) ? 32'(-((-33'(v)) >>> 1)) : (v >>> 1);
    endfunction

    // Weighted sum over six, truncated toward zero. Halve the magnitude, then
    // split it as nh*2^17 + nl: since 2^17 = 3*43690 + 2, the quotient by three
    // is nh*43690 + (2*nh + nl)/3, and the small remainder term divides by three
    // through a reciprocal multiply (exact below 2^19).
    function automatic logic signed [31:0] div6(input logic signed [34:0] v);
        logic [34:0] m;
        logic [33:0] n;
        logic [16:0] nh, nl;
        logic [18:0] t;
        logic [39:0] tp;
        logic [32:0] q;
        m = v[34] ? 35'(-v) : 35'(v);
        n = m[34:1];
        nh = n[33:17];
        nl = n[16:0];
        t = 19'({nh, 1'b0}) + 19'(nl);
        tp = 40'(t) * 40'd699051;
        q = 33'(nh) * 33'd43690 + 33'(tp[39:21]);
        div6 = v[34] ? 32'(-q) : q[31:0];
    endfunction

    // microsteps of one stage
    //  0: t0 = x*y          1: t0 = one - t0     2: t1 = one + Q
    //  3: t2 = Q + y, start divide               4: t2 = x - qt
    //  5: t1 = P*y          6: t1 = t1*t2        7: kx = h*t0
    //  8: ky = h*t1         9: accumulate, next stage input
    always_comb
    begin
        ma = '0; mb = '0; aa = '0; ab = '0; asub = 1'b0;
        state_next = state_reg;
        op_next = op_reg;
        stg_next = stg_reg;
        sx_next = sx_reg; sy_next = sy_reg;
        t0_next = t0_reg; t1_next = t1_reg; t2_next = t2_reg; qt_next = qt_reg;
        kx_next = kx_reg; ky_next = ky_reg;
        accx_next = accx_reg; accy_next = accy_reg;
        dvx_next = dvx_reg; dvy_next = dvy_reg;
        x_next = x_reg; y_next = y_reg;
        fl_next = fl_reg;
        dstart = 1'b0;
        take_in = 1'b0;
        fx = 1'b0; fy = 1'b0; nx = '0; ny = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && !(ovalid_reg && out_stall))
                begin
                    take_in = 1'b1;
                    if (restart)
                    begin
                        x_next = start_x;
                        y_next = start_y;
                    end
                    sx_next = restart ? start_x : x_reg;
                    sy_next = restart ? start_y : y_reg;
                    accx_next = '0; accy_next = '0;
                    fl_next = 1'b0;
                    stg_next = '0;
                    op_next = '0;
                    state_next = S_RUN;
                end
            end
            S_RUN:
            begin
                op_next = op_reg + 1'b1;
                case (op_reg)
                    4'd0:
                    begin
                        ma = sx_reg; mb = sy_reg; t0_next = mres;
                        fl_next = fl_reg | mfl | one_fl;
                    end
                    4'd1:
                    begin
                        aa = one_s; ab = t0_reg; asub = 1'b1;
                        t0_next = ares; fl_next = fl_reg | afl;
                    end
                    4'd2:
                    begin
                        aa = one_s; ab = q_reg; t1_next = ares; fl_next = fl_reg | afl;
                    end
                    4'd3:
                    begin
                        aa = q_reg; ab = sy_reg; t2_next = ares; fl_next = fl_reg | afl;
                        dstart = 1'b1;
                        state_next = S_DIV;
                    end
                    4'd4:
                    begin
                        aa = sx_reg; ab = qt_reg; asub = 1'b1;
                        t2_next = ares; fl_next = fl_reg | afl;
                    end
                    4'd5:
                    begin
                        ma = p_reg; mb = sy_reg; t1_next = mres; fl_next = fl_reg | mfl;
                    end
                    4'd6:
                    begin
                        ma = t1_reg; mb = t2_reg; t1_next = mres; fl_next = fl_reg | mfl;
                    end
                    4'd7:
                    begin
                        ma = h_s; mb = t0_reg; kx_next = mres; fl_next = fl_reg | mfl;
                    end
                    4'd8:
                    begin
                        ma = h_s; mb = t1_reg; ky_next = mres; fl_next = fl_reg | mfl;
                    end
                    default:
                    begin
                        op_next = '0;
                        if (stg_reg == 2'd0 || stg_reg == 2'd3)
                        begin
                            accx_next = accx_reg + 35'(kx_reg);
                            accy_next = accy_reg + 35'(ky_reg);
                        end
                        else
                        begin
                            accx_next = accx_reg + (35'(kx_reg) <<< 1);
                            accy_next = accy_reg + (35'(ky_reg) <<< 1);
                        end
                        if (stg_reg == 2'd3)
                        begin
                            state_next = S_FIN;
                        end
                        else
                        begin
                            if (stg_reg == 2'd2)
                            begin
                                sx_next = rk4_pkg::sat64(64'(x_reg) + 64'(kx_reg), fx);
                                sy_next = rk4_pkg::sat64(64'(y_reg) + 64'(ky_reg), fy);
                            end
                            else
                            begin
                                sx_next = rk4_pkg::sat64(64'(x_reg) + 64'(half(kx_reg)), fx);
                                sy_next = rk4_pkg::sat64(64'(y_reg) + 64'(half(ky_reg)), fy);
                            end
                            fl_next = fl_reg | fx | fy;
                            stg_next = stg_reg + 1'b1;
                        end
                    end
                endcase
            end
            S_DIV:
            begin
                if (drsp.done)
                begin
                    qt_next = drsp.quo;
                    fl_next = fl_reg | drsp.sat;
                    op_next = 4'd4;
                    state_next = S_RUN;
                end
            end
            S_FIN:
            begin
                // divide the weighted sum by six, truncating toward zero
                dvx_next = div6(accx_reg);
                dvy_next = div6(accy_reg);
                state_next = S_UPD;
            end
            S_UPD:
            begin
                nx = rk4_pkg::sat64(64'(x_reg) + 64'(dvx_reg), fx);
                ny = rk4_pkg::sat64(64'(y_reg) + 64'(dvy_reg), fy);
                fl_next = fl_reg | fx | fy;
                x_next = nx; y_next = ny;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign dreq.start = dstart;
    assign dreq.num = t1_next;
    assign dreq.den = t2_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg <= '0;
            stg_reg <= '0;
            h_reg <= 25'd167772;
            p_reg <= 32'sd25165824;
            q_reg <= 32'sd16777216;
            x_reg <= '0;
            y_reg <= '0;
            ovalid_reg <= 1'b0;
            div_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg <= op_next;
            stg_reg <= stg_next;
            x_reg <= x_next;
            y_reg <= y_next;
            div_pend_reg <= (state_next == S_DIV);
            if (cfg_we)
            begin
                case (cfg_index)
                    rk4_pkg::REG_STEP: h_reg <= cfg_data[24:0];
                    rk4_pkg::REG_GAIN: p_reg <= cfg_data;
                    rk4_pkg::REG_OFFS: q_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (state_reg == S_UPD)
            begin
                ovalid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sx_reg <= sx_next; sy_reg <= sy_next;
        t0_reg <= t0_next; t1_reg <= t1_next; t2_reg <= t2_next; qt_reg <= qt_next;
        kx_reg <= kx_next; ky_reg <= ky_next;
        accx_reg <= accx_next; accy_reg <= accy_next;
        dvx_reg <= dvx_next; dvy_reg <= dvy_next;
        fl_reg <= fl_next;
        if (take_in)
        begin
            ox_reg <= sx_next;
            oy_reg <= sy_next;
        end
        if (state_reg == S_UPD)
        begin
            osat_reg <= fl_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE) || (ovalid_reg && out_stall);
    assign out_valid = ovalid_reg;
    assign point_x_out = ox_reg;
    assign point_y_out = oy_reg;
    assign saturated = osat_reg;

    `ASSERT_IMPLY(a_busy_stall, clk, rst_n, state_reg != S_IDLE, in_stall)
    `ASSERT_NEXT(a_fin_valid, clk, rst_n, state_reg == S_UPD, out_valid)
    `ASSERT_IMPLY(a_div_wait, clk, rst_n, div_pend_reg && drsp.done, state_reg == S_DIV)
endmodule

@@ src/rk4_div.sv @@
// Restoring long divider, one quotient bit per cycle, saturating.
module rk4_div #(
    parameter int FRACTION_BITS = 24
) (
    input  logic             clk,
    input  logic             rst_n,
    input  rk4_pkg::div_req_t req,
    output rk4_pkg::div_rsp_t rsp
);
    localparam int NB = 32 + FRACTION_BITS;
    localparam int CW = $clog2(NB + 1);

    logic [NB-1:0] rem_reg, rem_next;
    logic [NB-1:0] q_reg, q_next;
    logic [NB-1:0] n_reg, n_next;
    logic [32:0]   d_reg, d_next;
    logic          neg_reg, neg_next;
    logic          busy_reg, busy_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          done_reg, done_next;
    logic          dz_reg, dz_next;

    logic [32:0] un, ud;
    logic [NB:0] sh;
    logic [NB-1:0] lim;
    logic over;

    always_comb
    begin
        un = req.num[31] ? 33'(-{req.num[31], req.num}) : {1'b0, req.num};
        ud = req.den[31] ? 33'(-{req.den[31], req.den}) : {1'b0, req.den};
        rem_next = rem_reg;
        q_next = q_reg;
        n_next = n_reg;
        d_next = d_reg;
        neg_next = neg_reg;
        busy_next = busy_reg;
        cnt_next = cnt_reg;
        done_next = 1'b0;
        dz_next = dz_reg;
        sh = '0;
        if (req.start)
        begin
            n_next = NB'(un) << FRACTION_BITS;
            d_next = ud;
            neg_next = req.num[31] ^ req.den[31];
            dz_next = (req.den == '0);
            rem_next = '0;
            q_next = '0;
            cnt_next = CW'(NB);
            busy_next = (req.den != '0);
            done_next = (req.den == '0);
        end
        else if (busy_reg)
        begin
            sh = {rem_reg, n_reg[NB-1]};
            n_next = n_reg << 1;
            if (sh >= (NB+1)'(d_reg))
            begin
                rem_next = NB'(sh - (NB+1)'(d_reg));
                q_next = {q_reg[NB-2:0], 1'b1};
            end
            else
            begin
                rem_next = NB'(sh);
                q_next = {q_reg[NB-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg <= q_next;
        n_reg <= n_next;
        d_reg <= d_next;
        neg_reg <= neg_next;
        dz_reg <= dz_next;
    end

    // quotient above 2^31 is overflow; exactly 2^31 only fits when negative
    always_comb
    begin
        lim = NB'(33'h1_0000_0000 >> 1);
        over = (q_reg > lim);
        rsp.done = done_reg;
        if (dz_reg)
        begin
            rsp.sat = 1'b1;
            rsp.quo = neg_reg ? rk4_pkg::I32_MIN : rk4_pkg::I32_MAX;
        end
        else if (over || (q_reg == lim && !neg_reg))
        begin
            rsp.sat = 1'b1;
            rsp.quo = neg_reg ? rk4_pkg::I32_MIN : rk4_pkg::I32_MAX;
        end
        else
        begin
            rsp.sat = 1'b0;
            rsp.quo = neg_reg ? 32'(-q_reg[31:0]) : q_reg[31:0];
        end
    end
endmodule
